>>> hw/rtl/tlaiv_pkg.sv
// Shared types, constants and the arctangent table for the two-link arm
// inverse-velocity pipeline. No dependencies.
package tlaiv_pkg;

    localparam int CORDIC_STAGES = 20;          // 12..32
    localparam int DIV_STEPS     = 33;          // quotient bits 32..0
    localparam int CW            = 34;          // CORDIC datapath, Q30
    localparam int NUMW          = 53;          // determinant and numerators, Q32
    localparam int RW            = NUMW + 17;   // divider remainder
    localparam int DIVW          = NUMW + DIV_STEPS; // divisor shifted by step

    localparam logic signed [CW-1:0] PI_Q30      = 34'sh0C90FDAA2;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sh1921FB544;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sh06487ED51;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sh026DD3B6A;

    localparam logic [1:0] CFG_LINK_ONE  = 2'd0;
    localparam logic [1:0] CFG_LINK_TWO  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    typedef logic signed [CW-1:0] cw_t;

    typedef struct packed {
        logic               vld;
        logic               neg1;
        logic               neg2;
        cw_t                x1;
        cw_t                y1;
        cw_t                z1;
        cw_t                x2;
        cw_t                y2;
        cw_t                z2;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
    } cordic_bus_t;

    typedef struct packed {
        logic                   vld;
        logic                   sing;
        logic                   neg0;
        logic                   neg1;
        logic                   big0;
        logic                   big1;
        logic [RW-1:0]          r0;
        logic [RW-1:0]          r1;
        logic [DIV_STEPS-1:0]   q0;
        logic [DIV_STEPS-1:0]   q1;
        logic [NUMW-1:0]        dmag;
        logic signed [31:0]     j00;
        logic signed [31:0]     j01;
        logic signed [31:0]     j10;
        logic signed [31:0]     j11;
        logic signed [NUMW-1:0] det;
    } div_bus_t;

    // atan(2^-i) in Q30, truncated
    function automatic cw_t atan_q30(input logic [4:0] idx);
        cw_t v;
        unique case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000007;
            5'd28: v = 34'sh000000003;
            5'd29: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/two_link_arm_inverse_velocity_top.sv
// Two-link planar arm inverse velocity: Jacobian, determinant, joint rates.
// Depends on tlaiv_pkg, tlaiv_cordic_cell, tlaiv_div_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  s_      | s_valid / s_ready    | angles (Q3.16), tip velocity (Q8.16)
//  m_      | m_valid / m_ready    | Jacobian, determinant, joint rates, flags
//  cfg_    | cfg_valid / cfg_ready| cfg_index, cfg_data (47 bits)
//
// One pose per cycle while the pipe is not stalled. The registered steps are:
// angle wrap, fold, the CORDIC cell row, four multiply/subtract stages,
// the setup of the division, the divider cell row and the output register.
// The whole pipe advances together; it stalls only while a result sits in
// the output register and m_ready is low. cfg_ready is always high.
// Reset clears the valid bits and loads the link lengths and threshold.
module two_link_arm_inverse_velocity_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [18:0] s_shoulder_angle,
    input  logic signed [18:0] s_elbow_angle,
    input  logic signed [23:0] s_velocity_x,
    input  logic signed [23:0] s_velocity_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_jac_row0_col0,
    output logic signed [31:0] m_jac_row0_col1,
    output logic signed [31:0] m_jac_row1_col0,
    output logic signed [31:0] m_jac_row1_col1,
    output logic signed [47:0] m_determinant,
    output logic signed [31:0] m_joint_one_rate,
    output logic signed [31:0] m_joint_two_rate,
    output logic               m_singular,
    output logic               m_saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [46:0]        cfg_data
);

    localparam int CW   = tlaiv_pkg::CW;
    localparam int NUMW = tlaiv_pkg::NUMW;
    localparam int RW   = tlaiv_pkg::RW;
    localparam int DS   = tlaiv_pkg::DIV_STEPS;
    localparam int CS   = tlaiv_pkg::CORDIC_STAGES;

    // ---------------- configuration registers ----------------
    logic [23:0] l1_reg, l2_reg;
    logic [46:0] thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg  <= 24'd131072;
            l2_reg  <= 24'd98304;
            thr_reg <= 47'd4295;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tlaiv_pkg::CFG_LINK_ONE:  l1_reg  <= cfg_data[23:0];
                tlaiv_pkg::CFG_LINK_TWO:  l2_reg  <= cfg_data[23:0];
                tlaiv_pkg::CFG_THRESHOLD: thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: the output register is empty or being drained.
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: angle to Q30, wrap into [-pi, pi] ----------------
    logic               w_vld_reg;
    tlaiv_pkg::cw_t     a1_reg, a2_reg, a1_next, a2_next;
    logic signed [23:0] w_vx_reg, w_vy_reg;
    logic signed [19:0] tsum;
    tlaiv_pkg::cw_t     r1, r2;

    always_comb begin
        tsum = 20'(s_shoulder_angle) + 20'(s_elbow_angle);
        r1   = CW'(s_shoulder_angle) <<< 14;
        r2   = CW'(tsum) <<< 14;
        a1_next = r1;
        a2_next = r2;
        if (r1 > tlaiv_pkg::PI_Q30)       a1_next = r1 - tlaiv_pkg::TWO_PI_Q30;
        else if (r1 < -tlaiv_pkg::PI_Q30) a1_next = r1 + tlaiv_pkg::TWO_PI_Q30;
        if (r2 > tlaiv_pkg::PI_Q30)       a2_next = r2 - tlaiv_pkg::TWO_PI_Q30;
        else if (r2 < -tlaiv_pkg::PI_Q30) a2_next = r2 + tlaiv_pkg::TWO_PI_Q30;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_vld_reg <= 1'b0;
        end else if (en) begin
            w_vld_reg <= s_valid;
            a1_reg    <= a1_next;
            a2_reg    <= a2_next;
            w_vx_reg  <= s_velocity_x;
            w_vy_reg  <= s_velocity_y;
        end
    end

    // ---------------- stage 2: fold into [-pi/2, pi/2] ----------------
    tlaiv_pkg::cordic_bus_t fold_reg, fold_next;

    always_comb begin
        fold_next.vld  = w_vld_reg;
        fold_next.x1   = tlaiv_pkg::GAIN_Q30;
        fold_next.y1   = '0;
        fold_next.x2   = tlaiv_pkg::GAIN_Q30;
        fold_next.y2   = '0;
        fold_next.vx   = w_vx_reg;
        fold_next.vy   = w_vy_reg;
        fold_next.z1   = a1_reg;
        fold_next.neg1 = 1'b0;
        fold_next.z2   = a2_reg;
        fold_next.neg2 = 1'b0;
        if (a1_reg > tlaiv_pkg::HALF_PI_Q30) begin
            fold_next.z1 = a1_reg - tlaiv_pkg::PI_Q30;  fold_next.neg1 = 1'b1;
        end else if (a1_reg < -tlaiv_pkg::HALF_PI_Q30) begin
            fold_next.z1 = a1_reg + tlaiv_pkg::PI_Q30;  fold_next.neg1 = 1'b1;
        end
        if (a2_reg > tlaiv_pkg::HALF_PI_Q30) begin
            fold_next.z2 = a2_reg - tlaiv_pkg::PI_Q30;  fold_next.neg2 = 1'b1;
        end else if (a2_reg < -tlaiv_pkg::HALF_PI_Q30) begin
            fold_next.z2 = a2_reg + tlaiv_pkg::PI_Q30;  fold_next.neg2 = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg.vld <= 1'b0;
        end else if (en) begin
            fold_reg <= fold_next;
        end
    end

    // ---------------- CORDIC cell row ----------------
    tlaiv_pkg::cordic_bus_t cbus [CS+1];
    assign cbus[0] = fold_reg;

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        tlaiv_cordic_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (5'(i)),
            .bus_in  (cbus[i]),
            .bus_out (cbus[i+1])
        );
    end

    // ---------------- stage M: link length times sin/cos ----------------
    tlaiv_pkg::cordic_bus_t cend;
    logic signed [31:0]     s1, c1, s12, c12;
    logic signed [56:0]     pp_reg, qp_reg, up_reg, wp_reg;
    logic                   mp_vld_reg;
    logic signed [23:0]     mp_vx_reg, mp_vy_reg;

    assign cend = cbus[CS];

    always_comb begin
        s1  = 32'(cend.neg1 ? -cend.y1 : cend.y1);
        c1  = 32'(cend.neg1 ? -cend.x1 : cend.x1);
        s12 = 32'(cend.neg2 ? -cend.y2 : cend.y2);
        c12 = 32'(cend.neg2 ? -cend.x2 : cend.x2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mp_vld_reg <= 1'b0;
        end else if (en) begin
            mp_vld_reg <= cend.vld;
            pp_reg     <= 57'($signed({1'b0, l1_reg}) * s1);
            qp_reg     <= 57'($signed({1'b0, l2_reg}) * s12);
            up_reg     <= 57'($signed({1'b0, l1_reg}) * c1);
            wp_reg     <= 57'($signed({1'b0, l2_reg}) * c12);
            mp_vx_reg  <= cend.vx;
            mp_vy_reg  <= cend.vy;
        end
    end

    // ---------------- stage J: round to Q16, form the Jacobian ----------------
    localparam logic signed [56:0] HALF_Q30 = 57'sd1 <<< 29;
    logic signed [56:0] pr, qr, ur, wr;
    logic signed [31:0] p_v, q_v, u_v, w_v;
    logic signed [31:0] p_reg, q_reg, u_reg, w_reg;
    logic signed [31:0] j00_reg, j01_reg, j10_reg, j11_reg;
    logic               j_vld_reg;
    logic signed [23:0] j_vx_reg, j_vy_reg;

    always_comb begin
        pr  = (pp_reg + HALF_Q30) >>> 30;
        qr  = (qp_reg + HALF_Q30) >>> 30;
        ur  = (up_reg + HALF_Q30) >>> 30;
        wr  = (wp_reg + HALF_Q30) >>> 30;
        p_v = pr[31:0];
        q_v = qr[31:0];
        u_v = ur[31:0];
        w_v = wr[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_vld_reg <= 1'b0;
        end else if (en) begin
            j_vld_reg <= mp_vld_reg;
            p_reg     <= p_v;
            q_reg     <= q_v;
            u_reg     <= u_v;
            w_reg     <= w_v;
            j00_reg   <= -(p_v + q_v);
            j01_reg   <= -q_v;
            j10_reg   <= u_v + w_v;
            j11_reg   <= w_v;
            j_vx_reg  <= mp_vx_reg;
            j_vy_reg  <= mp_vy_reg;
        end
    end

    // ---------------- stage K: products for det and numerators ----------------
    logic signed [63:0] qu_reg, pw_reg;
    logic signed [55:0] a0_reg, b0_reg, a1p_reg, b1_reg;
    logic signed [31:0] k00_reg, k01_reg, k10_reg, k11_reg;
    logic               k_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_vld_reg <= 1'b0;
        end else if (en) begin
            k_vld_reg <= j_vld_reg;
            qu_reg    <= q_reg * u_reg;
            pw_reg    <= p_reg * w_reg;
            a0_reg    <= 56'(j11_reg * j_vx_reg);
            b0_reg    <= 56'(j01_reg * j_vy_reg);
            a1p_reg   <= 56'(j00_reg * j_vy_reg);
            b1_reg    <= 56'(j10_reg * j_vx_reg);
            k00_reg   <= j00_reg;
            k01_reg   <= j01_reg;
            k10_reg   <= j10_reg;
            k11_reg   <= j11_reg;
        end
    end

    // ---------------- stage D: determinant and numerators ----------------
    logic signed [NUMW-1:0] det_reg, n0_reg, n1_reg;
    logic signed [31:0]     d00_reg, d01_reg, d10_reg, d11_reg;
    logic                   d_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= k_vld_reg;
            det_reg   <= NUMW'(qu_reg - pw_reg);
            n0_reg    <= NUMW'(a0_reg - b0_reg);
            n1_reg    <= NUMW'(a1p_reg - b1_reg);
            d00_reg   <= k00_reg;
            d01_reg   <= k01_reg;
            d10_reg   <= k10_reg;
            d11_reg   <= k11_reg;
        end
    end

    // ---------------- stage S: singular test, magnitudes, overflow check ----------------
    tlaiv_pkg::div_bus_t   dsetup_reg, dsetup_next;
    logic [NUMW-1:0]       dmag, nmag0, nmag1;
    logic [RW-1:0]         dlim;

    always_comb begin
        dmag  = det_reg[NUMW-1] ? NUMW'(-det_reg) : NUMW'(det_reg);
        nmag0 = n0_reg[NUMW-1]  ? NUMW'(-n0_reg)  : NUMW'(n0_reg);
        nmag1 = n1_reg[NUMW-1]  ? NUMW'(-n1_reg)  : NUMW'(n1_reg);
        dlim  = RW'(dmag) << 17;
        dsetup_next.vld  = d_vld_reg;
        dsetup_next.sing = (dmag == '0) || (dmag < NUMW'(thr_reg));
        dsetup_next.neg0 = n0_reg[NUMW-1] ^ det_reg[NUMW-1];
        dsetup_next.neg1 = n1_reg[NUMW-1] ^ det_reg[NUMW-1];
        dsetup_next.big0 = RW'(nmag0) >= dlim;
        dsetup_next.big1 = RW'(nmag1) >= dlim;
        dsetup_next.r0   = RW'(nmag0) << 16;
        dsetup_next.r1   = RW'(nmag1) << 16;
        dsetup_next.q0   = '0;
        dsetup_next.q1   = '0;
        dsetup_next.dmag = dmag;
        dsetup_next.j00  = d00_reg;
        dsetup_next.j01  = d01_reg;
        dsetup_next.j10  = d10_reg;
        dsetup_next.j11  = d11_reg;
        dsetup_next.det  = det_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dsetup_reg.vld <= 1'b0;
        end else if (en) begin
            dsetup_reg <= dsetup_next;
        end
    end

    // ---------------- divider cell row: quotient bits 32 down to 0 ----------------
    tlaiv_pkg::div_bus_t dbus [DS+1];
    assign dbus[0] = dsetup_reg;

    for (genvar k = 0; k < DS; k++) begin : g_div
        tlaiv_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (6'(DS - 1 - k)),
            .bus_in  (dbus[k]),
            .bus_out (dbus[k+1])
        );
    end

    // ---------------- output stage: round, saturate, clip ----------------
    tlaiv_pkg::div_bus_t dend;
    logic [33:0]         qv0, qv1, qr0, qr1;
    logic signed [31:0]  rate0, rate1;
    logic                sat0, sat1;
    logic signed [47:0]  det_clip;
    localparam logic [33:0] CAP_Q   = 34'h1_0000_0000;
    localparam logic [33:0] NEG_LIM = 34'h0_8000_0000;
    localparam logic [33:0] POS_LIM = 34'h0_7FFF_FFFF;
    localparam logic signed [NUMW-1:0] DET_MAX = NUMW'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [NUMW-1:0] DET_MIN = -(NUMW'(48'sh7FFF_FFFF_FFFF)) - 1;

    assign dend = dbus[DS];

    always_comb begin
        qv0 = dend.big0 ? CAP_Q : 34'(dend.q0);
        qv1 = dend.big1 ? CAP_Q : 34'(dend.q1);
        qr0 = qv0 + 34'(({dend.r0, 1'b0}) >= (RW+1)'(dend.dmag));
        qr1 = qv1 + 34'(({dend.r1, 1'b0}) >= (RW+1)'(dend.dmag));
        if (dend.neg0) begin
            sat0  = qr0 > NEG_LIM;
            rate0 = sat0 ? 32'sh8000_0000 : -$signed(qr0[31:0]);
        end else begin
            sat0  = qr0 > POS_LIM;
            rate0 = sat0 ? 32'sh7FFF_FFFF : $signed(qr0[31:0]);
        end
        if (dend.neg1) begin
            sat1  = qr1 > NEG_LIM;
            rate1 = sat1 ? 32'sh8000_0000 : -$signed(qr1[31:0]);
        end else begin
            sat1  = qr1 > POS_LIM;
            rate1 = sat1 ? 32'sh7FFF_FFFF : $signed(qr1[31:0]);
        end
        if (dend.det > DET_MAX)      det_clip = 48'sh7FFF_FFFF_FFFF;
        else if (dend.det < DET_MIN) det_clip = 48'sh8000_0000_0000;
        else                         det_clip = dend.det[47:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg      <= dend.vld;
            m_jac_row0_col0  <= dend.j00;
            m_jac_row0_col1  <= dend.j01;
            m_jac_row1_col0  <= dend.j10;
            m_jac_row1_col1  <= dend.j11;
            m_determinant    <= det_clip;
            m_singular       <= dend.sing;
            m_joint_one_rate <= dend.sing ? '0 : rate0;
            m_joint_two_rate <= dend.sing ? '0 : rate1;
            m_saturated      <= !dend.sing && (sat0 || sat1);
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> hw/rtl/tlaiv_cordic_cell.sv
// One rotation-mode CORDIC stage for both joint angles, registered.
// Depends on tlaiv_pkg.
module tlaiv_cordic_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [4:0]            idx,
    input  tlaiv_pkg::cordic_bus_t bus_in,
    output tlaiv_pkg::cordic_bus_t bus_out
);

    tlaiv_pkg::cordic_bus_t bus_reg, bus_next;
    tlaiv_pkg::cw_t         dx1, dy1, dx2, dy2, at;

    always_comb begin
        dx1 = bus_in.y1 >>> idx;
        dy1 = bus_in.x1 >>> idx;
        dx2 = bus_in.y2 >>> idx;
        dy2 = bus_in.x2 >>> idx;
        at  = tlaiv_pkg::atan_q30(idx);
        bus_next = bus_in;
        if (!bus_in.z1[tlaiv_pkg::CW-1]) begin
            bus_next.x1 = bus_in.x1 - dx1;
            bus_next.y1 = bus_in.y1 + dy1;
            bus_next.z1 = bus_in.z1 - at;
        end else begin
            bus_next.x1 = bus_in.x1 + dx1;
            bus_next.y1 = bus_in.y1 - dy1;
            bus_next.z1 = bus_in.z1 + at;
        end
        if (!bus_in.z2[tlaiv_pkg::CW-1]) begin
            bus_next.x2 = bus_in.x2 - dx2;
            bus_next.y2 = bus_in.y2 + dy2;
            bus_next.z2 = bus_in.z2 - at;
        end else begin
            bus_next.x2 = bus_in.x2 + dx2;
            bus_next.y2 = bus_in.y2 - dy2;
            bus_next.z2 = bus_in.z2 + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_reg.vld <= 1'b0;
        end else if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

>>> hw/rtl/tlaiv_div_cell.sv
// One restoring-division step for both joint-rate numerators, registered.
// Depends on tlaiv_pkg.
module tlaiv_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [5:0]          idx,
    input  tlaiv_pkg::div_bus_t bus_in,
    output tlaiv_pkg::div_bus_t bus_out
);

    tlaiv_pkg::div_bus_t           bus_reg, bus_next;
    logic [tlaiv_pkg::DIVW-1:0]    sh;
    logic                          ge0, ge1;

    always_comb begin
        sh  = tlaiv_pkg::DIVW'(bus_in.dmag) << idx;
        ge0 = tlaiv_pkg::DIVW'(bus_in.r0) >= sh;
        ge1 = tlaiv_pkg::DIVW'(bus_in.r1) >= sh;
        bus_next = bus_in;
        bus_next.r0 = ge0 ? bus_in.r0 - tlaiv_pkg::RW'(sh) : bus_in.r0;
        bus_next.r1 = ge1 ? bus_in.r1 - tlaiv_pkg::RW'(sh) : bus_in.r1;
        bus_next.q0 = {bus_in.q0[tlaiv_pkg::DIV_STEPS-2:0], ge0};
        bus_next.q1 = {bus_in.q1[tlaiv_pkg::DIV_STEPS-2:0], ge1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_reg.vld <= 1'b0;
        end else if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule
